// ===== hdl/fir_filter_loadable_taps_macros.svh =====
// Assertion macros for the loadable-tap FIR filter.
// No dependencies; included by the RTL files that carry assertions.
`ifndef FIR_FILTER_LOADABLE_TAPS_MACROS_SVH
`define FIR_FILTER_LOADABLE_TAPS_MACROS_SVH

`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define FIRLT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
// expr must never be true at a clock edge outside reset
`define FIRLT_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);
`else
`define FIRLT_ASSERT(lbl, clk, rst_n, prop, msg)
`define FIRLT_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ===== hdl/firlt_pkg.sv =====
// Package for the loadable-tap FIR filter: field widths, command codes, state type.
// No dependencies.
`default_nettype none

package firlt_pkg;

    localparam int SAMPLE_W   = 16;  // Q1.15 sample
    localparam int COEF_W     = 18;  // Q2.16 coefficient
    localparam int PROD_W     = SAMPLE_W + COEF_W;  // Q3.31 product
    localparam int OUT_W      = 16;  // Q1.15 result
    localparam int CFG_W      = 9;   // tap count register
    localparam int IDX_W      = 8;   // coefficient index field
    localparam int FRAC_SHIFT = 16;  // Q3.31 -> Q1.15

    localparam logic [CFG_W-1:0] TAP_COUNT_RST = 9'd256;

    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/fir_filter_loadable_taps.sv =====
// Loadable-tap direct-form FIR filter, one shared multiply-accumulate.
// Depends on firlt_pkg and fir_filter_loadable_taps_macros.svh.
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_stall   i_cmd, i_sample, i_tap_index, i_tap_value
//  out      output     o_out_valid / i_out_stall o_filtered, o_saturated
//  cfg      input      i_cfg_valid / o_cfg_ready i_cfg_data (tap_count)
//
// A coefficient load transaction completes in the cycle it is accepted.
// A sample transaction holds off the input while it walks n = min(tap_count, MAX_TAPS) taps:
// one multiply-accumulate per tap through the shared multiplier, then the read/product
// pipeline drains until it is seen empty, then a round-and-saturate step into the
// output register. An empty sum (n = 0) still passes through the MAC and round steps.
// After reset a clearing pass over all MAX_TAPS addresses zeros both memories; input is stalled
// meanwhile, config writes are taken at any time.
// The result waits in the output register under i_out_stall; a new sample can be accepted
// and computed, it only waits at the final step if the old result has not left yet.
`default_nettype none
`include "fir_filter_loadable_taps_macros.svh"

module fir_filter_loadable_taps #(
    parameter int MAX_TAPS = 256
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // input item channel
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic                                 i_cmd,
    input  wire logic signed [firlt_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic        [firlt_pkg::IDX_W-1:0]    i_tap_index,
    input  wire logic signed [firlt_pkg::COEF_W-1:0]   i_tap_value,
    // result channel
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic signed      [firlt_pkg::OUT_W-1:0]    o_filtered,
    output logic                                      o_saturated,
    // configuration channel
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic        [firlt_pkg::CFG_W-1:0]    i_cfg_data
);

    import firlt_pkg::*;

    // address width of the memories, count width that can hold MAX_TAPS itself
    localparam int AW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW   = $clog2(MAX_TAPS + 1);
    localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;
    // exact accumulator: product width plus growth over MAX_TAPS terms, one spare bit
    localparam int ACCW = PROD_W + 1 + $clog2(MAX_TAPS);
    localparam int QW   = ACCW - FRAC_SHIFT;

    localparam logic [AW-1:0]   LAST_ADDR = AW'(MAX_TAPS - 1);
    localparam logic [CMPW-1:0] TAPS_LIM  = CMPW'(MAX_TAPS);
    localparam logic signed [ACCW-1:0] ROUND_HALF =
        {{(ACCW - FRAC_SHIFT){1'b0}}, 1'b1, {(FRAC_SHIFT - 1){1'b0}}};
    localparam logic signed [QW-1:0] Q_MAX =
        {{(QW - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
    localparam logic signed [QW-1:0] Q_MIN =
        {{(QW - OUT_W + 1){1'b1}}, {(OUT_W - 1){1'b0}}};

    // memories: delay line is a circular buffer, newest sample at r_head
    logic signed [SAMPLE_W-1:0] delay_mem [MAX_TAPS];
    logic signed [COEF_W-1:0]   coef_mem  [MAX_TAPS];

    // control state
    t_state           r_state, n_state;
    logic [AW-1:0]    r_head, n_head;
    logic [AW-1:0]    r_clr_addr, n_clr_addr;
    logic [CW-1:0]    r_issue_left, n_issue_left;
    logic [AW-1:0]    r_caddr, n_caddr;
    logic [AW-1:0]    r_daddr, n_daddr;
    logic             r_v1, r_v2;
    logic             r_out_valid, n_out_valid;
    logic [CFG_W-1:0] r_tap_count;

    // datapath
    logic signed [COEF_W-1:0]   r_rd_c;
    logic signed [SAMPLE_W-1:0] r_rd_d;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACCW-1:0]     r_acc, n_acc;
    logic signed [OUT_W-1:0]    r_out_data, n_out_data;
    logic                       r_out_sat, n_out_sat;

    // memory write ports
    logic                       w_c_we, w_d_we;
    logic [AW-1:0]              w_c_waddr, w_d_waddr;
    logic signed [COEF_W-1:0]   w_c_wdata;
    logic signed [SAMPLE_W-1:0] w_d_wdata;

    logic                       w_in_acc, w_out_take, w_issue;
    logic [CMPW-1:0]            w_tc_ext;
    logic [CW-1:0]              w_ntaps;
    logic [AW-1:0]              w_head_dec;
    logic signed [ACCW-1:0]     w_rnd;
    logic signed [QW-1:0]       w_q;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_filtered  = r_out_data;
    assign o_saturated = r_out_sat;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_take = r_out_valid && !i_out_stall;

    // taps used per sum, clamped to the table depth
    assign w_tc_ext = CMPW'(r_tap_count);
    assign w_ntaps  = (w_tc_ext > TAPS_LIM) ? CW'(TAPS_LIM) : CW'(w_tc_ext);

    assign w_head_dec = (r_head == '0) ? LAST_ADDR : r_head - AW'(1);
    assign w_issue    = (r_state == ST_MAC) && (r_issue_left != '0);

    // round half up into Q1.15, then clip
    assign w_rnd = r_acc + ROUND_HALF;
    assign w_q   = $signed(w_rnd[ACCW-1:FRAC_SHIFT]);

    // tap count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tap_count <= i_cfg_data;
        end
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_head       <= '0;
            r_clr_addr   <= '0;
            r_issue_left <= '0;
            r_caddr      <= '0;
            r_daddr      <= '0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_clr_addr   <= n_clr_addr;
            r_issue_left <= n_issue_left;
            r_caddr      <= n_caddr;
            r_daddr      <= n_daddr;
            r_v1         <= w_issue;
            r_v2         <= r_v1;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_acc      <= n_acc;
        r_out_data <= n_out_data;
        r_out_sat  <= n_out_sat;
        r_prod     <= r_rd_c * r_rd_d;
    end

    // memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (w_c_we) begin
            coef_mem[w_c_waddr] <= w_c_wdata;
        end
        r_rd_c <= coef_mem[r_caddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_d_we) begin
            delay_mem[w_d_waddr] <= w_d_wdata;
        end
        r_rd_d <= delay_mem[r_daddr];
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_clr_addr   = r_clr_addr;
        n_issue_left = r_issue_left;
        n_caddr      = r_caddr;
        n_daddr      = r_daddr;
        n_acc        = r_acc;
        n_out_data   = r_out_data;
        n_out_sat    = r_out_sat;
        n_out_valid  = r_out_valid && !w_out_take;
        w_c_we       = 1'b0;
        w_c_waddr    = AW'(i_tap_index);
        w_c_wdata    = i_tap_value;
        w_d_we       = 1'b0;
        w_d_waddr    = w_head_dec;
        w_d_wdata    = i_sample;

        unique case (r_state)
            ST_CLEAR: begin
                w_c_we    = 1'b1;
                w_c_waddr = r_clr_addr;
                w_c_wdata = '0;
                w_d_we    = 1'b1;
                w_d_waddr = r_clr_addr;
                w_d_wdata = '0;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + AW'(1);
                end
            end
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_cmd == CMD_LOAD) begin
                        // indexes past the table are dropped
                        w_c_we = (32'(i_tap_index) < MAX_TAPS);
                    end else begin
                        w_d_we       = 1'b1;
                        n_head       = w_head_dec;
                        n_caddr      = '0;
                        n_daddr      = w_head_dec;
                        n_issue_left = w_ntaps;
                        n_acc        = '0;
                        n_state      = ST_MAC;
                    end
                end
            end
            ST_MAC: begin
                if (w_issue) begin
                    n_issue_left = r_issue_left - CW'(1);
                    n_caddr      = r_caddr + AW'(1);
                    n_daddr      = (r_daddr == LAST_ADDR) ? '0 : r_daddr + AW'(1);
                end
                if (r_v2) begin
                    n_acc = r_acc + {{(ACCW - PROD_W){r_prod[PROD_W-1]}}, r_prod};
                end
                if (!w_issue && !r_v1 && !r_v2) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // wait until the output register is free
                if (!r_out_valid || w_out_take) begin
                    n_out_valid = 1'b1;
                    if (w_q > Q_MAX) begin
                        n_out_data = Q_MAX[OUT_W-1:0];
                        n_out_sat  = 1'b1;
                    end else if (w_q < Q_MIN) begin
                        n_out_data = Q_MIN[OUT_W-1:0];
                        n_out_sat  = 1'b1;
                    end else begin
                        n_out_data = w_q[OUT_W-1:0];
                        n_out_sat  = 1'b0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // a sample transaction starts the walk over exactly the clamped tap count
    `FIRLT_ASSERT(a_mac_start, i_clk, i_rst_n, w_in_acc && (i_cmd == CMD_FILTER) |=> (r_state == ST_MAC) && (r_issue_left == $past(w_ntaps)), "MAC walk did not start with the tap count")
    // a coefficient load never starts a computation
    `FIRLT_ASSERT(a_load_idle, i_clk, i_rst_n, w_in_acc && (i_cmd == CMD_LOAD) |=> (r_state == ST_IDLE), "coefficient load left idle")
    // rounding only sees a fully drained pipeline
    `FIRLT_ASSERT(a_drained, i_clk, i_rst_n, (r_state == ST_DONE) |-> !r_v1 && !r_v2 && (r_issue_left == '0), "round step before pipeline drained")
    // a clipped result sits at one of the two limits
    `FIRLT_ASSERT(a_sat_limit, i_clk, i_rst_n, r_out_valid && r_out_sat |-> (o_filtered == Q_MAX[OUT_W-1:0]) || (o_filtered == Q_MIN[OUT_W-1:0]), "saturated result not at a limit")
    // the clearing pass runs with the delay line head parked at zero
    `FIRLT_ASSERT_NEVER(a_clr_head, i_clk, i_rst_n, (r_state == ST_CLEAR) && (r_head != '0), "head moved during clearing pass")

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the loadable-tap FIR filter (fir_filter_loadable_taps).
// Depends on firlt_pkg and the RTL only; a built-in predictor checks every filtered sample.
`timescale 1ns / 100ps

module tb;
    import firlt_pkg::*;

    localparam int NTAPS     = 256;   // matches the DUT default MAX_TAPS
    localparam int PHASE_LEN = 140;   // items per random phase
    localparam int HOLD_CYC  = 400;   // long receiver hold-off for back-pressure

    // one input transaction and one result transaction
    typedef struct packed {
        logic                       cmd;
        logic signed [SAMPLE_W-1:0] sample;
        logic        [IDX_W-1:0]    tap_index;
        logic signed [COEF_W-1:0]   tap_value;
    } t_fir_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] filtered;
        logic                    saturated;
    } t_fir_out;

    // clock, reset and DUT-facing signals, the driven inputs known from time zero
    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    logic                       i_cmd       = CMD_FILTER;
    logic signed [SAMPLE_W-1:0] i_sample    = '0;
    logic        [IDX_W-1:0]    i_tap_index = '0;
    logic signed [COEF_W-1:0]   i_tap_value = '0;
    logic                       i_out_stall = 1'b0;
    logic                       i_cfg_valid = 1'b0;
    logic        [CFG_W-1:0]    i_cfg_data  = '0;
    logic                       o_in_stall;
    logic                       o_out_valid;
    logic signed [OUT_W-1:0]    o_filtered;
    logic                       o_saturated;
    logic                       o_cfg_ready;

    // stimulus and scoreboard storage
    t_fir_item pending_items [$];
    t_fir_out  expected_filt [$];

    // predictor state: history (newest at 0), tap table, tap count
    logic signed [SAMPLE_W-1:0] fir_hist [NTAPS];
    logic signed [COEF_W-1:0]   fir_coef [NTAPS];
    logic        [CFG_W-1:0]    taps_used = TAP_COUNT_RST;

    // idle / stall control
    int unsigned idle_pct_in   = 0;
    int unsigned stall_pct_out = 0;
    bit          hold_go       = 1'b0;
    bit          hold_off      = 1'b0;

    bit in_taken     = 1'b0;   // input transaction completed at the last rising edge
    int mismatch_cnt = 0;
    int fail_cnt     = 0;

    fir_filter_loadable_taps #(
        .MAX_TAPS(NTAPS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_sample    (i_sample),
        .i_tap_index (i_tap_index),
        .i_tap_value (i_tap_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_filtered  (o_filtered),
        .o_saturated (o_saturated),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        for (int k = 0; k < NTAPS; k++) begin
            fir_hist[k] = '0;
            fir_coef[k] = '0;
        end
    end

    // Filter step: a load writes one tap and yields nothing; a sample shifts
    // the history, takes the exact dot product, rounds half up to Q1.15 and clips.
    function automatic bit fir_filter_step(input t_fir_item it, output t_fir_out res);
        longint acc;
        longint q;
        int     n;
        int     i;
        acc = 0;
        res = '0;
        if (it.cmd == CMD_LOAD) begin
            fir_coef[it.tap_index] = it.tap_value;
            return 1'b0;
        end
        for (i = NTAPS - 1; i > 0; i--)
            fir_hist[i] = fir_hist[i-1];
        fir_hist[0] = it.sample;
        n = (taps_used > NTAPS) ? NTAPS : int'(taps_used);
        for (i = 0; i < n; i++)
            acc += longint'(fir_coef[i]) * longint'(fir_hist[i]);
        q = (acc + 32768) >>> FRAC_SHIFT;   // floor division: exact halves go up
        if (q > 32767) begin
            q = 32767;
            res.saturated = 1'b1;
        end else if (q < -32768) begin
            q = -32768;
            res.saturated = 1'b1;
        end
        res.filtered = q[OUT_W-1:0];
        return 1'b1;
    endfunction

    // Input side at the rising edge: note completion for the driver, predict
    // every accepted transaction, track tap count writes.
    always @(posedge i_clk) begin : in_watch
        t_fir_item it;
        t_fir_out  res;
        in_taken <= i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            it.cmd       = i_cmd;
            it.sample    = i_sample;
            it.tap_index = i_tap_index;
            it.tap_value = i_tap_value;
            if (fir_filter_step(it, res))
                expected_filt.insert(expected_filt.size(), res);
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready)
            taps_used = i_cfg_data;
    end

    // Input driver at the falling edge: hold the payload until it is taken,
    // then either idle or present the next queued item.
    always @(negedge i_clk) begin : in_drive
        t_fir_item it;
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct_in) begin
                it = pending_items.pop_front();
                i_in_valid  <= 1'b1;
                i_cmd       <= it.cmd;
                i_sample    <= it.sample;
                i_tap_index <= it.tap_index;
                i_tap_value <= it.tap_value;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random per phase, forced high during the hold-off.
    always @(negedge i_clk) begin
        if (i_rst_n)
            i_out_stall <= hold_off || ($urandom_range(99) < stall_pct_out);
    end

    // Long hold-off, counted in its own process, so the block backs up and
    // stalls its input while the sender keeps offering.
    initial begin : rx_hold
        wait (hold_go);
        hold_off = 1'b1;
        repeat (HOLD_CYC) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Output checker: each completed result against the oldest prediction.
    always @(posedge i_clk) begin : out_check
        t_fir_out exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_filt.size() == 0) begin
                fail_cnt++;
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("ERROR: unexpected result filtered=%0d saturated=%0b",
                             o_filtered, o_saturated);
            end else begin
                exp_r = expected_filt.pop_front();
                if (o_filtered !== exp_r.filtered || o_saturated !== exp_r.saturated) begin
                    fail_cnt++;
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("ERROR: filtered exp %0d got %0d, saturated exp %0b got %0b",
                                 exp_r.filtered, o_filtered, exp_r.saturated, o_saturated);
                end
            end
        end
    end

    // queue a filter transaction; unused fields carry random noise
    task automatic push_sample(input int s);
        t_fir_item it;
        it.cmd       = CMD_FILTER;
        it.sample    = s[SAMPLE_W-1:0];
        it.tap_index = IDX_W'($urandom);
        it.tap_value = COEF_W'($urandom);
        pending_items.insert(pending_items.size(), it);
    endtask

    // queue a coefficient load; unused sample field carries random noise
    task automatic push_load(input int idx, input int val);
        t_fir_item it;
        it.cmd       = CMD_LOAD;
        it.sample    = SAMPLE_W'($urandom);
        it.tap_index = idx[IDX_W-1:0];
        it.tap_value = val[COEF_W-1:0];
        pending_items.insert(pending_items.size(), it);
    endtask

    // wait until every item is sent and every result is back, then let any
    // trailing load settle before touching the tap count
    task automatic drain();
        while (pending_items.size() > 0 || i_in_valid || expected_filt.size() > 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_tap_count(input logic [CFG_W-1:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int rand_sample();
        case ($urandom_range(7))
            0:       return 32767;
            1:       return -32768;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    // a share of small taps so sums stay in range, with random and full-scale ones mixed in
    function automatic int rand_coef();
        case ($urandom_range(7))
            0:          return 131071;
            1:          return -131072;
            2, 3, 4:    return int'($urandom_range(8191)) - 4096;
            default:    return int'($urandom_range(262143)) - 131072;
        endcase
    endfunction

    initial begin : stim
        logic [CFG_W-1:0] phase_taps [8];
        int               lim;

        phase_taps = '{9'd2, TAP_COUNT_RST, 9'd5, 9'd17, 9'd64, 9'd300, 9'd1, 9'd128};

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset tap count; zero table first
        push_sample(32767);
        push_load(0, 131071);          // full-scale positive tap
        push_load(1, -131072);         // full-scale negative tap
        push_load(255, 131071);        // last table slot
        push_sample(32767);
        push_sample(-32768);           // drives the sum below range
        push_sample(32767);            // drives the sum above range
        push_sample(0);
        push_load(0, 1);
        push_load(1, 0);
        push_sample(-32768);           // exact half: rounds up to zero
        push_sample(32767);            // just under a half: rounds to zero
        push_load(0, 2);
        push_sample(-32768);
        drain();

        // empty sum
        set_tap_count('0);
        push_sample(32767);
        push_sample(-32768);
        drain();

        // single tap, saturating both ways
        set_tap_count(9'd1);
        push_load(0, 131071);
        push_sample(32767);
        push_sample(-32768);
        drain();

        // all ones: clamps to the table size
        set_tap_count('1);
        push_sample(1);
        drain();

        // random phases cycling through the idle patterns
        for (int p = 0; p < 8; p++) begin
            set_tap_count(phase_taps[p]);
            case (p % 4)
                0: begin idle_pct_in = 0;  stall_pct_out = 0;  end
                1: begin idle_pct_in = 59; stall_pct_out = 0;  end
                2: begin idle_pct_in = 0;  stall_pct_out = 59; end
                default: begin idle_pct_in = 10; stall_pct_out = 10; end
            endcase
            lim = (phase_taps[p] > NTAPS || phase_taps[p] == 0) ? NTAPS : int'(phase_taps[p]);
            for (int k = 0; k < PHASE_LEN; k++) begin
                if ($urandom_range(9) < 3) begin
                    if ($urandom_range(3) == 0)
                        push_load($urandom_range(255), rand_coef());
                    else
                        push_load($urandom_range(lim - 1), rand_coef());
                end else begin
                    push_sample(rand_sample());
                end
            end
            if (p == 0) begin
                @(posedge i_clk);
                hold_go = 1'b1;   // back-pressure with the sender running flat out
            end
            drain();
        end

        repeat (300) @(negedge i_clk);
        if (fail_cnt == 0 && expected_filt.size() == 0)
            $display("PASS fir_filter_loadable_taps");
        else
            $display("FAIL fir_filter_loadable_taps");
        $finish;
    end

    initial begin : watchdog
        #40_000_000;
        $display("FAIL fir_filter_loadable_taps");
        $finish;
    end

endmodule
